/* sv/fbwf_pkg.sv */
// ----------------------------------------------------------------------------
// fbwf_pkg
// Shared types, register indexes and constants for the fuel and battery
// warning flasher.
// ----------------------------------------------------------------------------
package fbwf_pkg;

  // field widths
  localparam int unsigned FuelW  = 7;
  localparam int unsigned BattW  = 22;
  localparam int unsigned DelayW = 8;
  localparam int unsigned PhaseW = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FUEL_HIGH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FUEL_LOW    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BATT_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BATT_LOW    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ALARM_DELAY = 3'd4;

  // register reset values
  localparam logic [FuelW-1:0]  FUEL_HIGH_RST   = 7'd50;
  localparam logic [FuelW-1:0]  FUEL_LOW_RST    = 7'd10;
  localparam logic [BattW-1:0]  BATT_HIGH_RST   = 22'd1800000;
  localparam logic [BattW-1:0]  BATT_LOW_RST    = 22'd360000;
  localparam logic [DelayW-1:0] ALARM_DELAY_RST = 8'd150;

  // phase periods and pattern step points
  localparam logic [PhaseW-1:0] PERIOD_HALF  = 7'd10;
  localparam logic [PhaseW-1:0] PERIOD_FULL  = 7'd20;
  localparam logic [PhaseW-1:0] PERIOD_ALARM = 7'd100;
  localparam logic [PhaseW-1:0] STEP_0  = 7'd0;
  localparam logic [PhaseW-1:0] STEP_5  = 7'd5;
  localparam logic [PhaseW-1:0] STEP_10 = 7'd10;
  localparam logic [PhaseW-1:0] STEP_15 = 7'd15;
  localparam logic [PhaseW-1:0] ALARM_TOGGLE_MAX = 7'd50;
  localparam logic [DelayW-1:0] DELAY_MAX = 8'd255;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2
  } band_t;

  typedef struct packed {
    logic [FuelW-1:0]  fuel_high;
    logic [FuelW-1:0]  fuel_low;
    logic [BattW-1:0]  batt_high;
    logic [BattW-1:0]  batt_low;
    logic [DelayW-1:0] alarm_delay;
  } cfg_t;

  typedef struct packed {
    band_t fuel;
    band_t batt;
  } bands_t;

  typedef struct packed {
    logic led1;
    logic led2;
    logic led3;
    logic battery_low;
    logic fuel_low;
    logic alarm_pulse;
  } result_t;

endpackage

/* sv/fuel_battery_warning_flasher.sv */
// ----------------------------------------------------------------------------
// fuel_battery_warning_flasher
// Fuel and battery band warning with LED blink patterns and an
// over-temperature alarm; one result beat per input tick.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    fuel_level, battery_level,
//                                              over_temperature
//   out      output     out_valid / out_ready  led1..3, battery_low,
//                                              fuel_low, alarm_pulse
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat a cycle while out_ready holds; a result is offered once it has
// passed the input register, then band and pattern logic into the result
// register; a stall on out_ready can hold it in the input register.
// while a result waits on out_ready, one more beat is taken into the input
// register, then in_ready drops until the waiting result leaves.
// reset restores the register defaults and clears phase, delay and leds.
// cfg_ready is always high; writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module fuel_battery_warning_flasher
  import fbwf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FuelW-1:0]    in_fuel_level,
  input  logic [BattW-1:0]    in_battery_level,
  input  logic                in_over_temperature,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_led1,
  output logic                out_led2,
  output logic                out_led3,
  output logic                out_battery_low,
  output logic                out_fuel_low,
  output logic                out_alarm_pulse,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  bands_t  bands;
  result_t result;

  logic             s1_valid_r, s1_valid_nxt;
  logic [FuelW-1:0] s1_fuel_r;
  logic [BattW-1:0] s1_batt_r;
  logic             s1_hot_r;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r;

  logic in_fire;
  logic step_fire;

  assign cfg_ready = 1'b1;

  fbwf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake control
  assign step_fire = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || step_fire;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_fuel_r <= in_fuel_level;
      s1_batt_r <= in_battery_level;
      s1_hot_r  <= in_over_temperature;
    end
  end

  fbwf_band u_band (
    .cfg           (cfg),
    .fuel_level    (s1_fuel_r),
    .battery_level (s1_batt_r),
    .bands         (bands)
  );

  fbwf_pattern u_pattern (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_fire),
    .hot         (s1_hot_r),
    .bands       (bands),
    .alarm_delay (cfg.alarm_delay),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led1        = out_r.led1;
  assign out_led2        = out_r.led2;
  assign out_led3        = out_r.led3;
  assign out_battery_low = out_r.battery_low;
  assign out_fuel_low    = out_r.fuel_low;
  assign out_alarm_pulse = out_r.alarm_pulse;

endmodule

/* sv/fbwf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fbwf_cfg_regs
// Configuration register file, written one beat at a time by index.
// ----------------------------------------------------------------------------
module fbwf_cfg_regs
  import fbwf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // index decode, writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_FUEL_HIGH:   cfg_nxt.fuel_high   = wr_data[FuelW-1:0];
        CFG_FUEL_LOW:    cfg_nxt.fuel_low    = wr_data[FuelW-1:0];
        CFG_BATT_HIGH:   cfg_nxt.batt_high   = wr_data[BattW-1:0];
        CFG_BATT_LOW:    cfg_nxt.batt_low    = wr_data[BattW-1:0];
        CFG_ALARM_DELAY: cfg_nxt.alarm_delay = wr_data[DelayW-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fuel_high   <= FUEL_HIGH_RST;
      cfg_r.fuel_low    <= FUEL_LOW_RST;
      cfg_r.batt_high   <= BATT_HIGH_RST;
      cfg_r.batt_low    <= BATT_LOW_RST;
      cfg_r.alarm_delay <= ALARM_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/fbwf_band.sv */
// ----------------------------------------------------------------------------
// fbwf_band
// Sorts fuel and battery levels into high, middle and low bands.
// ----------------------------------------------------------------------------
module fbwf_band
  import fbwf_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [FuelW-1:0] fuel_level,
  input  logic [BattW-1:0] battery_level,
  output bands_t           bands
);

  band_t fuel_band;
  band_t batt_band;
  logic  batt_mid;

  // fuel band
  always_comb begin
    if (fuel_level > cfg.fuel_high) begin
      fuel_band = BAND_HIGH;
    end else if (fuel_level > cfg.fuel_low) begin
      fuel_band = BAND_MID;
    end else begin
      fuel_band = BAND_LOW;
    end
  end

  // lower battery bound is inclusive when fuel is high
  assign batt_mid = (fuel_band == BAND_HIGH) ? (battery_level >= cfg.batt_low)
                                             : (battery_level >  cfg.batt_low);

  // battery band
  always_comb begin
    if (battery_level > cfg.batt_high) begin
      batt_band = BAND_HIGH;
    end else if (batt_mid) begin
      batt_band = BAND_MID;
    end else begin
      batt_band = BAND_LOW;
    end
  end

  assign bands = '{fuel: fuel_band, batt: batt_band};

endmodule

/* sv/fbwf_pattern.sv */
// ----------------------------------------------------------------------------
// fbwf_pattern
// Phase counter, alarm delay and LED pattern state; computes one result per
// beat and updates the state when the beat is taken.
// ----------------------------------------------------------------------------
module fbwf_pattern
  import fbwf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              hot,
  input  bands_t            bands,
  input  logic [DelayW-1:0] alarm_delay,
  output result_t           result
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [DelayW-1:0] delay_r, delay_nxt;
  logic              toggle_r, toggle_nxt;
  logic [2:0]        led_r, led_nxt;

  logic [PhaseW-1:0] phase_inc;
  logic [PhaseW-1:0] period;
  logic              advance;

  assign phase_inc = phase_r + 1'b1;

  // led update and phase period per mode
  always_comb begin
    led_nxt    = led_r;
    toggle_nxt = toggle_r;
    delay_nxt  = delay_r;
    period     = PERIOD_FULL;
    advance    = 1'b1;
    if (hot) begin
      advance = (delay_r >= alarm_delay);
      period  = PERIOD_ALARM;
      if (advance) begin
        toggle_nxt = (phase_r <= ALARM_TOGGLE_MAX) ? ~toggle_r : 1'b1;
        led_nxt[0] = toggle_nxt;
        led_nxt[1] = toggle_nxt;
      end
      if (delay_r != DELAY_MAX) begin
        delay_nxt = delay_r + 1'b1;
      end
    end else begin
      case (bands.fuel)
        BAND_HIGH: begin
          case (bands.batt)
            BAND_HIGH: begin
              led_nxt = 3'b100;
              advance = 1'b0;
            end
            BAND_MID: begin
              led_nxt[0] = 1'b0;
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0)  led_nxt[1] = 1'b1;
              if (phase_r == STEP_10) led_nxt[1] = 1'b0;
            end
            default: begin
              led_nxt[0] = 1'b0;
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0) led_nxt[1] = 1'b1;
              if (phase_r == STEP_5) led_nxt[1] = 1'b0;
              period = PERIOD_HALF;
            end
          endcase
        end
        BAND_MID: begin
          case (bands.batt)
            BAND_HIGH: begin
              led_nxt[1] = 1'b0;
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0)  led_nxt[0] = 1'b1;
              if (phase_r == STEP_10) led_nxt[0] = 1'b0;
            end
            BAND_MID: begin
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0)  led_nxt[1:0] = 2'b11;
              if (phase_r == STEP_10) led_nxt[1:0] = 2'b00;
            end
            default: begin
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0)  led_nxt[1:0] = 2'b11;
              if (phase_r == STEP_5)  led_nxt[1]   = 1'b0;
              if (phase_r == STEP_10) led_nxt[1:0] = 2'b10;
              if (phase_r == STEP_15) led_nxt[1]   = 1'b0;
            end
          endcase
        end
        default: begin
          case (bands.batt)
            BAND_HIGH: begin
              led_nxt[1] = 1'b0;
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0) led_nxt[0] = 1'b1;
              if (phase_r == STEP_5) led_nxt[0] = 1'b0;
              period = PERIOD_HALF;
            end
            BAND_MID: begin
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0)  led_nxt[1:0] = 2'b11;
              if (phase_r == STEP_5)  led_nxt[0]   = 1'b0;
              if (phase_r == STEP_10) led_nxt[1:0] = 2'b01;
              if (phase_r == STEP_15) led_nxt[0]   = 1'b0;
            end
            default: begin
              led_nxt[2] = 1'b0;
              if (phase_r == STEP_0) led_nxt[1:0] = 2'b11;
              if (phase_r == STEP_5) led_nxt[1:0] = 2'b00;
              period = PERIOD_HALF;
            end
          endcase
        end
      endcase
    end
  end

  // phase advance with wrap at or beyond the period
  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      phase_nxt = (phase_inc >= period) ? '0 : phase_inc;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      delay_r  <= '0;
      toggle_r <= 1'b0;
      led_r    <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      delay_r  <= delay_nxt;
      toggle_r <= toggle_nxt;
      led_r    <= led_nxt;
    end
  end

  // result fields
  always_comb begin
    result.led1        = led_nxt[0];
    result.led2        = led_nxt[1];
    result.led3        = led_nxt[2];
    result.battery_low = !hot && (bands.batt == BAND_LOW);
    result.fuel_low    = !hot && (bands.fuel == BAND_LOW);
    result.alarm_pulse = hot;
  end

endmodule
